// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define GRW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition implies a consequence on the following edge.
`define GRW_ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/grw_pkg.sv =====
// ----------------------------------------------------------------------------
// grw_pkg
// Types and constants of the grid ray wall search block.
// ----------------------------------------------------------------------------
package grw_pkg;

   // Request command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_CAST  = 1'b1;

   // Fixed-point constants
   localparam int ONE_Q16   = 65536;
   localparam int FRAC_BITS = 16;

   // Shared divider widths: 2^32 over a 34-bit magnitude
   localparam int DIV_NUM_W = 33;
   localparam int DIV_DEN_W = 34;

   typedef enum logic [2:0] {
      CSR_POS_ROW      = 3'd0,
      CSR_POS_COL      = 3'd1,
      CSR_DIR_ROW      = 3'd2,
      CSR_DIR_COL      = 3'd3,
      CSR_PLANE_ROW    = 3'd4,
      CSR_PLANE_COL    = 3'd5,
      CSR_SCREEN_WIDTH = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic        [21:0] pos_row;
      logic        [21:0] pos_col;
      logic signed [17:0] dir_row;
      logic signed [17:0] dir_col;
      logic signed [17:0] plane_row;
      logic signed [17:0] plane_col;
      logic        [12:0] screen_width;
   } cfg_type;

   typedef struct packed {
      logic        is_cast;
      logic [11:0] column;
      logic [5:0]  cell_row;
      logic [5:0]  cell_col;
      logic        cell_wall;
   } req_item_type;

   typedef struct packed {
      logic [11:0] cast_column;
      logic        found;
      logic [5:0]  hit_row;
      logic [5:0]  hit_col;
      logic        side;
      logic [31:0] side_dist_row;
      logic [31:0] side_dist_col;
   } rsp_item_type;

   typedef struct packed {
      logic valid;
      logic take;
   } item_hs_type;

   typedef struct packed {
      logic clearing;
      logic busy;
   } back_status_type;

   typedef enum logic [3:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_CX_WAIT,
      BK_RAY_MUL,
      BK_RAY_SUM,
      BK_DR_START,
      BK_DR_WAIT,
      BK_DC_WAIT,
      BK_INIT_MUL,
      BK_INIT_SAT,
      BK_STEP,
      BK_CHECK,
      BK_DONE
   } back_state_type;

endpackage

// ===== hw/rtl/grid_ray_wall_search.sv =====
// Grid ray wall search: column ray caster over a square wall map.
// Requests enter through a queue port (req_push / req_full). A request with
// cmd 0 writes one wall bit of the map and gives no response; cmd 1 casts the
// ray of one screen column and gives exactly one response.
// Responses leave through a queue port (rsp_empty / rsp_pop), oldest first.
// Camera registers are written on the csr_ port; the user must do so only
// while the block is idle, which the block itself does not enforce. A map
// write is done in the execute stage. A cast uses the shared bit-serial
// divider (camera x and both reciprocals) and setup states, then grid steps
// (step, then registered map read), up to STEP_LIMIT steps, then the output.
// A two-entry request queue lets requests arrive while a cast is running.
// After reset the map is cleared one cell a cycle, MAP_SIDE * MAP_SIDE cells
// (4096 by default); req_full stays high during that pass.
// While rsp_pop is held low a finished response waits in the output register,
// the execute stage holds the next response and the queue fills, then
// req_full rises.
// ----------------------------------------------------------------------------
// grid_ray_wall_search
// Top level: configuration registers, front queue and execute stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module grid_ray_wall_search import grw_pkg::*; #(
   parameter int MAP_SIDE   = 64,
   parameter int STEP_LIMIT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_cmd,
   input  logic [11:0] req_column,
   input  logic [5:0]  req_cell_row,
   input  logic [5:0]  req_cell_col,
   input  logic        req_cell_wall,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [11:0] rsp_cast_column,
   output logic        rsp_found,
   output logic [5:0]  rsp_hit_row,
   output logic [5:0]  rsp_hit_col,
   output logic        rsp_side,
   output logic [31:0] rsp_side_dist_row,
   output logic [31:0] rsp_side_dist_col,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [21:0] csr_wdata
);

   cfg_type         cfg_ff, cfg_in;
   item_hs_type     hs;
   logic            item_valid;
   req_item_type    item;
   logic            rsp_valid;
   rsp_item_type    rsp;
   back_status_type status;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_POS_ROW:      cfg_in.pos_row      = csr_wdata;
            CSR_POS_COL:      cfg_in.pos_col      = csr_wdata;
            CSR_DIR_ROW:      cfg_in.dir_row      = csr_wdata[17:0];
            CSR_DIR_COL:      cfg_in.dir_col      = csr_wdata[17:0];
            CSR_PLANE_ROW:    cfg_in.plane_row    = csr_wdata[17:0];
            CSR_PLANE_COL:    cfg_in.plane_col    = csr_wdata[17:0];
            CSR_SCREEN_WIDTH: cfg_in.screen_width = csr_wdata[12:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pos_row      <= 22'd2162688;
         cfg_ff.pos_col      <= 22'd2162688;
         cfg_ff.dir_row      <= 18'sd0;
         cfg_ff.dir_col      <= 18'sd65536;
         cfg_ff.plane_row    <= 18'sd43254;
         cfg_ff.plane_col    <= 18'sd0;
         cfg_ff.screen_width <= 13'd640;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   grw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .hold       (status.clearing),
      .cmd        (req_cmd),
      .column     (req_column),
      .cell_row   (req_cell_row),
      .cell_col   (req_cell_col),
      .cell_wall  (req_cell_wall),
      .full       (req_full),
      .hs_in      (hs),
      .item_valid (item_valid),
      .item       (item)
   );

   grw_back #(
      .MAP_SIDE   (MAP_SIDE),
      .STEP_LIMIT (STEP_LIMIT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .hs_out     (hs),
      .rsp_pop    (rsp_pop),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp),
      .status     (status)
   );

   assign rsp_empty         = !rsp_valid;
   assign rsp_cast_column   = rsp.cast_column;
   assign rsp_found         = rsp.found;
   assign rsp_hit_row       = rsp.hit_row;
   assign rsp_hit_col       = rsp.hit_col;
   assign rsp_side          = rsp.side;
   assign rsp_side_dist_row = rsp.side_dist_row;
   assign rsp_side_dist_col = rsp.side_dist_col;

   // Map clearing blocks new requests and the queue drain
   `GRW_ASSERT(a_clear_blocks_req, !status.clearing || req_full, "request taken during clear")
   `GRW_ASSERT(a_clear_no_take, !status.clearing || !hs.take, "queue drained during clear")
   // A miss reports no hit cell
   `GRW_ASSERT(a_miss_zero, rsp_empty || rsp_found ||
      (rsp_hit_row == 6'd0 && rsp_hit_col == 6'd0 && !rsp_side), "miss carries hit data")
   // An unpopped response stays
   `GRW_ASSERT_NEXT(a_rsp_hold, !rsp_empty && !rsp_pop, !rsp_empty, "response dropped")

endmodule

// ===== hw/rtl/grw_div.sv =====
// ----------------------------------------------------------------------------
// grw_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module grw_div import grw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic                 valid,
   output logic [DIV_NUM_W-1:0] quo
);

   localparam int CW = $clog2(DIV_NUM_W + 1);

   logic                 busy_ff, busy_in;
   logic                 valid_ff, valid_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;
   logic                 ge;

   // Shift in one numerator bit and try the subtract
   always_comb begin
      trial = {rem_ff, quo_ff[DIV_NUM_W-1]};
      diff  = trial - {1'b0, den_ff};
      ge    = trial >= {1'b0, den_ff};
      busy_in  = busy_ff;
      valid_in = valid_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         valid_in = 1'b0;
         cnt_in   = '0;
         rem_in   = '0;
         den_in   = den;
         quo_in   = num;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         quo_in = {quo_ff[DIV_NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DIV_NUM_W - 1)) begin
            busy_in  = 1'b0;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign valid = valid_ff;
   assign quo   = quo_ff;

endmodule

// ===== hw/rtl/grw_front.sv =====
// ----------------------------------------------------------------------------
// grw_front
// Accepts requests, tags them as map write or cast and queues them.
// ----------------------------------------------------------------------------
module grw_front import grw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic         hold,
   input  logic         cmd,
   input  logic [11:0]  column,
   input  logic [5:0]   cell_row,
   input  logic [5:0]   cell_col,
   input  logic         cell_wall,
   output logic         full,
   input  item_hs_type  hs_in,
   output logic         item_valid,
   output req_item_type item
);

   req_item_type q_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         do_push, do_pop;
   req_item_type new_item;

   // Classify the incoming request
   always_comb begin
      new_item.is_cast   = (cmd == CMD_CAST);
      new_item.column    = column;
      new_item.cell_row  = cell_row;
      new_item.cell_col  = cell_col;
      new_item.cell_wall = cell_wall;
   end

   assign full       = (cnt_ff == 2'd2) || hold;
   assign do_push    = push && !full;
   assign do_pop     = hs_in.take && (cnt_ff != 2'd0);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = q_ff[rd_ptr_ff];

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ===== hw/rtl/grw_back.sv =====
// ----------------------------------------------------------------------------
// grw_back
// Executes queued requests: map writes, ray setup and the grid walk.
// ----------------------------------------------------------------------------
module grw_back import grw_pkg::*; #(
   parameter int MAP_SIDE   = 64,
   parameter int STEP_LIMIT = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            item_valid,
   input  req_item_type    item,
   output item_hs_type     hs_out,
   input  logic            rsp_pop,
   output logic            rsp_valid,
   output rsp_item_type    rsp,
   output back_status_type status
);

   localparam int CELLS = MAP_SIDE * MAP_SIDE;
   localparam int AW    = $clog2(CELLS);
   localparam int IW    = (($clog2(MAP_SIDE) > 6) ? $clog2(MAP_SIDE) : 6) + 2;
   localparam int NW    = $clog2(STEP_LIMIT + 1);

   back_state_type state_ff, state_in;
   logic [AW-1:0]  clr_ff, clr_in;
   req_item_type   item_ff, item_in;
   logic signed [30:0] cx_ff, cx_in;
   logic signed [48:0] prod_r_ff, prod_r_in, prod_c_ff, prod_c_in;
   logic signed [33:0] ray_r_ff, ray_r_in, ray_c_ff, ray_c_in;
   logic [31:0]    dr_ff, dr_in, dc_ff, dc_in;
   logic [48:0]    ip_r_ff, ip_r_in, ip_c_ff, ip_c_in;
   logic [31:0]    sdr_ff, sdr_in, sdc_ff, sdc_in;
   logic signed [IW-1:0] r_ff, r_in, c_ff, c_in;
   logic           side_ff, side_in;
   logic           found_ff, found_in;
   logic [NW-1:0]  n_ff, n_in;
   rsp_item_type   out_ff, out_in;
   logic           out_valid_ff, out_valid_in;

   logic           mem [CELLS];
   logic           mem_rdata_ff;
   logic           mem_we;
   logic [AW-1:0]  mem_waddr;
   logic           mem_wdata;
   logic [AW-1:0]  rd_addr;

   logic                 div_start;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic                 div_valid;
   logic [DIV_NUM_W-1:0] div_quo;

   logic [12:0]    width_eff;
   logic [DIV_DEN_W-1:0] abs_r, abs_c;
   logic [16:0]    d_r, d_c;
   logic [32:0]    add_r, add_c;
   logic signed [IW-1:0] r_next, c_next;
   logic           next_in_map;
   logic           out_load;

   grw_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .valid (div_valid),
      .quo   (div_quo)
   );

   // Operand shaping
   always_comb begin
      width_eff = (cfg.screen_width == 13'd0) ? 13'd1 : cfg.screen_width;
      abs_r = ray_r_ff[33] ? DIV_DEN_W'(-ray_r_ff) : DIV_DEN_W'(ray_r_ff);
      abs_c = ray_c_ff[33] ? DIV_DEN_W'(-ray_c_ff) : DIV_DEN_W'(ray_c_ff);
      d_r = ray_r_ff[33] ? {1'b0, cfg.pos_row[15:0]}
                         : 17'(ONE_Q16) - {1'b0, cfg.pos_row[15:0]};
      d_c = ray_c_ff[33] ? {1'b0, cfg.pos_col[15:0]}
                         : 17'(ONE_Q16) - {1'b0, cfg.pos_col[15:0]};
      add_r = {1'b0, sdr_ff} + {1'b0, dr_ff};
      add_c = {1'b0, sdc_ff} + {1'b0, dc_ff};
   end

   // Pick the next cell along the axis with the smaller side distance
   always_comb begin
      r_next = r_ff;
      c_next = c_ff;
      if (sdr_ff < sdc_ff) begin
         r_next = ray_r_ff[33] ? r_ff - IW'(1) : r_ff + IW'(1);
      end else begin
         c_next = ray_c_ff[33] ? c_ff - IW'(1) : c_ff + IW'(1);
      end
      next_in_map = (r_next >= 0) && (int'(r_next) < MAP_SIDE) &&
                    (c_next >= 0) && (int'(c_next) < MAP_SIDE);
      rd_addr = AW'(int'(r_next) * MAP_SIDE + int'(c_next));
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      item_in   = item_ff;
      cx_in     = cx_ff;
      prod_r_in = prod_r_ff;
      prod_c_in = prod_c_ff;
      ray_r_in  = ray_r_ff;
      ray_c_in  = ray_c_ff;
      dr_in     = dr_ff;
      dc_in     = dc_ff;
      ip_r_in   = ip_r_ff;
      ip_c_in   = ip_c_ff;
      sdr_in    = sdr_ff;
      sdc_in    = sdc_ff;
      r_in      = r_ff;
      c_in      = c_ff;
      side_in   = side_ff;
      found_in  = found_ff;
      n_in      = n_ff;
      hs_out.valid = item_valid;
      hs_out.take  = 1'b0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      mem_we    = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = 1'b0;
      out_load  = 1'b0;
      out_in    = out_ff;

      unique case (state_ff)
         BK_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(CELLS - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (item_valid) begin
               hs_out.take = 1'b1;
               item_in     = item;
               if (item.is_cast) begin
                  div_start = 1'b1;
                  div_num   = DIV_NUM_W'({item.column, 17'd0});
                  div_den   = DIV_DEN_W'(width_eff);
                  state_in  = BK_CX_WAIT;
               end else if ((int'(item.cell_row) < MAP_SIDE) &&
                            (int'(item.cell_col) < MAP_SIDE)) begin
                  mem_we    = 1'b1;
                  mem_waddr = AW'(int'(item.cell_row) * MAP_SIDE + int'(item.cell_col));
                  mem_wdata = item.cell_wall;
               end
            end
         end
         BK_CX_WAIT: begin
            if (div_valid) begin
               cx_in    = $signed({2'b00, div_quo[28:0]}) - 31'sd65536;
               state_in = BK_RAY_MUL;
            end
         end
         BK_RAY_MUL: begin
            prod_r_in = $signed(cfg.plane_row) * cx_ff;
            prod_c_in = $signed(cfg.plane_col) * cx_ff;
            state_in  = BK_RAY_SUM;
         end
         BK_RAY_SUM: begin
            ray_r_in = 34'(prod_r_ff >>> FRAC_BITS) + 34'($signed(cfg.dir_row));
            ray_c_in = 34'(prod_c_ff >>> FRAC_BITS) + 34'($signed(cfg.dir_col));
            state_in = BK_DR_START;
         end
         BK_DR_START: begin
            div_start = 1'b1;
            div_num   = {1'b1, 32'd0};
            div_den   = abs_r;
            state_in  = BK_DR_WAIT;
         end
         BK_DR_WAIT: begin
            if (div_valid) begin
               dr_in     = div_quo[32] ? 32'hFFFF_FFFF : div_quo[31:0];
               div_start = 1'b1;
               div_num   = {1'b1, 32'd0};
               div_den   = abs_c;
               state_in  = BK_DC_WAIT;
            end
         end
         BK_DC_WAIT: begin
            if (div_valid) begin
               dc_in    = div_quo[32] ? 32'hFFFF_FFFF : div_quo[31:0];
               state_in = BK_INIT_MUL;
            end
         end
         BK_INIT_MUL: begin
            ip_r_in  = 49'(d_r) * 49'(dr_ff);
            ip_c_in  = 49'(d_c) * 49'(dc_ff);
            state_in = BK_INIT_SAT;
         end
         BK_INIT_SAT: begin
            sdr_in   = ip_r_ff[48] ? 32'hFFFF_FFFF : ip_r_ff[47:16];
            sdc_in   = ip_c_ff[48] ? 32'hFFFF_FFFF : ip_c_ff[47:16];
            r_in     = $signed(IW'(cfg.pos_row[21:16]));
            c_in     = $signed(IW'(cfg.pos_col[21:16]));
            side_in  = 1'b0;
            found_in = 1'b0;
            n_in     = '0;
            if ((int'(cfg.pos_row[21:16]) < MAP_SIDE) &&
                (int'(cfg.pos_col[21:16]) < MAP_SIDE)) begin
               state_in = BK_STEP;
            end else begin
               state_in = BK_DONE;
            end
         end
         BK_STEP: begin
            if (sdr_ff < sdc_ff) begin
               sdr_in  = add_r[32] ? 32'hFFFF_FFFF : add_r[31:0];
               side_in = 1'b0;
            end else begin
               sdc_in  = add_c[32] ? 32'hFFFF_FFFF : add_c[31:0];
               side_in = 1'b1;
            end
            r_in     = r_next;
            c_in     = c_next;
            n_in     = n_ff + 1'b1;
            state_in = next_in_map ? BK_CHECK : BK_DONE;
         end
         BK_CHECK: begin
            if (mem_rdata_ff) begin
               found_in = 1'b1;
               state_in = BK_DONE;
            end else if (n_ff == NW'(STEP_LIMIT)) begin
               state_in = BK_DONE;
            end else begin
               state_in = BK_STEP;
            end
         end
         BK_DONE: begin
            if (!out_valid_ff || rsp_pop) begin
               out_load              = 1'b1;
               out_in.cast_column    = item_ff.column;
               out_in.found          = found_ff;
               out_in.hit_row        = found_ff ? r_ff[5:0] : 6'd0;
               out_in.hit_col        = found_ff ? c_ff[5:0] : 6'd0;
               out_in.side           = found_ff ? side_ff : 1'b0;
               out_in.side_dist_row  = sdr_ff;
               out_in.side_dist_col  = sdc_ff;
               state_in              = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
      out_valid_in = out_load || (out_valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
      item_ff   <= item_in;
      cx_ff     <= cx_in;
      prod_r_ff <= prod_r_in;
      prod_c_ff <= prod_c_in;
      ray_r_ff  <= ray_r_in;
      ray_c_ff  <= ray_c_in;
      dr_ff     <= dr_in;
      dc_ff     <= dc_in;
      ip_r_ff   <= ip_r_in;
      ip_c_ff   <= ip_c_in;
      sdr_ff    <= sdr_in;
      sdc_ff    <= sdc_in;
      r_ff      <= r_in;
      c_ff      <= c_in;
      side_ff   <= side_in;
      found_ff  <= found_in;
      n_ff      <= n_in;
      out_ff    <= out_in;
   end

   // Wall map store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[rd_addr];
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp             = out_ff;
   assign status.clearing = (state_ff == BK_CLEAR);
   assign status.busy     = (state_ff != BK_IDLE);

endmodule
